FILE: src/yqrgb_pkg.sv
// yqrgb_pkg: shared types, constants and lookup tables for the yuv 4:2:0 quad to rgb unit
// used by yqrgb_front, yqrgb_pixel and yuv420_quad_to_rgb_unit; no dependencies
package yqrgb_pkg;

  localparam int unsigned PIX_W    = 8;   // one color or luma sample
  localparam int unsigned CHROMA_W = 10;  // signed chroma offset, -258..256
  localparam int unsigned PROD_W   = 10;  // rounded weighted color, 0..762
  localparam int unsigned GSUM_W   = 13;  // signed green sum, -1053..2550
  localparam int unsigned NUM_W    = 19;  // green numerator, up to 299187
  localparam int unsigned RECIP_W  = 18;
  localparam int unsigned QUAD_N   = 4;

  // green = floor(num / 1174) by multiply with a rounded-up reciprocal, exact for num <= 328160
  localparam logic [RECIP_W-1:0] G_RECIP   = 18'd228651;
  localparam int unsigned        G_SHIFT   = 28;
  localparam logic [NUM_W-1:0]   G_BIAS    = 19'd587;
  // sums at or above this give 255 or more
  localparam logic signed [GSUM_W-1:0] G_SAT_MIN = 13'sd1494;

  typedef logic [PIX_W-1:0]                 pix_tab_t    [256];
  typedef logic signed [CHROMA_W-1:0]       chroma_tab_t [256];
  typedef logic [PROD_W-1:0]                prod_tab_t   [256];
  typedef logic [QUAD_N-1:0][PIX_W-1:0]     quad_t;

  // chroma offsets and valid flag handed from the front stage to the pixel lanes
  typedef struct packed {
    logic                       valid;
    logic signed [CHROMA_W-1:0] uf;
    logic signed [CHROMA_W-1:0] vf;
  } chroma_t;

  // video range luma to full range, truncated and saturated
  function automatic pix_tab_t build_ys_tab();
    pix_tab_t tab;
    longint   t;
    for (int i = 0; i < 256; i++) begin
      if (i < 16) begin
        t = 0;
      end else begin
        t = (longint'(i - 16) * 64'sd10000000) / 64'sd8588235;
        if (t > 255) t = 255;
      end
      tab[i] = PIX_W'(t);
    end
    return tab;
  endfunction

  // round half away from zero of (i-128)*num/1000
  function automatic chroma_tab_t build_chroma_tab(input int num);
    chroma_tab_t tab;
    int          k;
    int          v;
    for (int i = 0; i < 256; i++) begin
      k = i - 128;
      if (k < 0) v = -(((-k) * num + 500) / 1000);
      else v = (k * num + 500) / 1000;
      tab[i] = CHROMA_W'(v);
    end
    return tab;
  endfunction

  // rounded i*num/100
  function automatic prod_tab_t build_prod_tab(input int num);
    prod_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = PROD_W'((num * i + 50) / 100);
    end
    return tab;
  endfunction

  localparam pix_tab_t    YS_TAB = build_ys_tab();
  localparam chroma_tab_t UF_TAB = build_chroma_tab(2018);
  localparam chroma_tab_t VF_TAB = build_chroma_tab(1596);
  localparam prod_tab_t   PR_TAB = build_prod_tab(299);
  localparam prod_tab_t   PB_TAB = build_prod_tab(114);

endpackage

FILE: src/yqrgb_front.sv
// yqrgb_front: input register stage, luma expansion and chroma offset lookups
// depends on yqrgb_pkg
module yqrgb_front import yqrgb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  quad_t   luma_i,
  input  logic [PIX_W-1:0] u_i,
  input  logic [PIX_W-1:0] v_i,
  output quad_t   ys_o,
  output chroma_t chroma_o
);

  logic  valid_q;
  quad_t ys_q;
  logic signed [CHROMA_W-1:0] uf_q, vf_q;

  // valid flag of the stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  // table lookups, loaded per transaction
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int i = 0; i < QUAD_N; i++) begin
        ys_q[i] <= YS_TAB[luma_i[i]];
      end
      uf_q <= UF_TAB[u_i];
      vf_q <= VF_TAB[v_i];
    end
  end

  assign ys_o     = ys_q;
  assign chroma_o = '{valid: valid_q, uf: uf_q, vf: vf_q};

endmodule

FILE: src/yqrgb_pixel.sv
// yqrgb_pixel: four-stage color lane, red/blue clamp, green sum and green scaling
// depends on yqrgb_pkg
module yqrgb_pixel import yqrgb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [PIX_W-1:0] ys_i,
  input  chroma_t          chroma_i,
  output logic             valid_o,
  output logic [PIX_W-1:0] red_o,
  output logic [PIX_W-1:0] green_o,
  output logic [PIX_W-1:0] blue_o
);

  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  logic [3:0] valid_q;

  logic [PIX_W-1:0] ys2_q, r2_q, b2_q, r3_q, b3_q, r4_q, b4_q;
  logic [PIX_W-1:0] r2_d, b2_d;
  logic [PIX_W-1:0] r5_q, g5_q, b5_q, g5_d;
  logic signed [GSUM_W-1:0] g3_q, g3_d, ys_ext;
  logic [NUM_W-1:0] n4_q, n4_d, g_num;
  logic             zero4_q, sat4_q, zero4_d, sat4_d;
  logic signed [CHROMA_W:0] sum_r, sum_b;
  logic [NUM_W+RECIP_W-1:0] prod;

  // valid bits travel with the lane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], chroma_i.valid};
    end
  end

  // stage 2: add chroma offsets, clamp red and blue
  always_comb begin
    sum_r = signed'({3'b000, ys_i}) + (CHROMA_W+1)'(chroma_i.vf);
    sum_b = signed'({3'b000, ys_i}) + (CHROMA_W+1)'(chroma_i.uf);
    if (sum_r < 0) r2_d = '0;
    else if (sum_r > signed'({3'b000, PIX_MAX})) r2_d = PIX_MAX;
    else r2_d = sum_r[PIX_W-1:0];
    if (sum_b < 0) b2_d = '0;
    else if (sum_b > signed'({3'b000, PIX_MAX})) b2_d = PIX_MAX;
    else b2_d = sum_b[PIX_W-1:0];
  end

  // stage 3: green sum 10*ys - rounded 2.99*r - rounded 1.14*b
  always_comb begin
    ys_ext = signed'({5'b00000, ys2_q});
    g3_d   = (ys_ext <<< 3) + (ys_ext <<< 1)
           - signed'({3'b000, PR_TAB[r2_q]})
           - signed'({3'b000, PB_TAB[b2_q]});
  end

  // stage 4: range flags and numerator 200*g + 587
  always_comb begin
    zero4_d = g3_q < 0;
    sat4_d  = g3_q >= G_SAT_MIN;
    g_num   = NUM_W'(g3_q[10:0]);
    n4_d    = (g_num << 7) + (g_num << 6) + (g_num << 3) + G_BIAS;
  end

  // stage 5: divide by 1174 through the reciprocal, then select
  always_comb begin
    prod = NUM_W'(n4_q) * RECIP_W'(G_RECIP);
    if (zero4_q) g5_d = '0;
    else if (sat4_q) g5_d = PIX_MAX;
    else g5_d = prod[G_SHIFT +: PIX_W];
  end

  // payload registers of all stages
  always_ff @(posedge clk_i) begin
    ys2_q   <= ys_i;
    r2_q    <= r2_d;
    b2_q    <= b2_d;
    g3_q    <= g3_d;
    r3_q    <= r2_q;
    b3_q    <= b2_q;
    zero4_q <= zero4_d;
    sat4_q  <= sat4_d;
    n4_q    <= n4_d;
    r4_q    <= r3_q;
    b4_q    <= b3_q;
    r5_q    <= r4_q;
    g5_q    <= g5_d;
    b5_q    <= b4_q;
  end

  assign valid_o = valid_q[3];
  assign red_o   = r5_q;
  assign green_o = g5_q;
  assign blue_o  = b5_q;

`ifndef SYNTHESIS
  // in-range green numerator stays under the exact reciprocal bound
  a_num_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] && !zero4_q && !sat4_q |-> n4_q <= 19'd299187)
    else $error("green numerator out of range");
`endif

endmodule

FILE: src/yuv420_quad_to_rgb_unit.sv
// yuv420_quad_to_rgb_unit: 2x2 luma quad plus shared chroma to four rgb pixels
// each taken quad goes through the lookup and lane stages to the result ports, done_o high
// throughput: one quad per cycle, set by the five-stage pipeline; busy stays low
// reset: rst_ni clears all valid bits at once, no results are pending afterwards
// depends on yqrgb_pkg, yqrgb_front, yqrgb_pixel
module yuv420_quad_to_rgb_unit import yqrgb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] luma_top_left_i,
  input  logic [7:0] luma_top_right_i,
  input  logic [7:0] luma_bottom_left_i,
  input  logic [7:0] luma_bottom_right_i,
  input  logic [7:0] chroma_u_i,
  input  logic [7:0] chroma_v_i,
  output logic       done_o,
  output logic [7:0] red_top_left_o,
  output logic [7:0] green_top_left_o,
  output logic [7:0] blue_top_left_o,
  output logic [7:0] red_top_right_o,
  output logic [7:0] green_top_right_o,
  output logic [7:0] blue_top_right_o,
  output logic [7:0] red_bottom_left_o,
  output logic [7:0] green_bottom_left_o,
  output logic [7:0] blue_bottom_left_o,
  output logic [7:0] red_bottom_right_o,
  output logic [7:0] green_bottom_right_o,
  output logic [7:0] blue_bottom_right_o
);

  logic    accept;
  quad_t   luma, ys;
  chroma_t chroma;
  logic [QUAD_N-1:0]            lane_valid;
  logic [QUAD_N-1:0][PIX_W-1:0] red, green, blue;

  // fully pipelined and never stalled by the receiver
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign luma = {luma_bottom_right_i, luma_bottom_left_i, luma_top_right_i, luma_top_left_i};

  // lookup stage
  yqrgb_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i (accept),
    .luma_i   (luma),
    .u_i      (chroma_u_i),
    .v_i      (chroma_v_i),
    .ys_o     (ys),
    .chroma_o (chroma)
  );

  // one color lane per pixel of the quad
  for (genvar i = 0; i < QUAD_N; i++) begin : g_lane
    yqrgb_pixel u_pixel (
      .clk_i,
      .rst_ni,
      .ys_i     (ys[i]),
      .chroma_i (chroma),
      .valid_o  (lane_valid[i]),
      .red_o    (red[i]),
      .green_o  (green[i]),
      .blue_o   (blue[i])
    );
  end

  // result transaction
  assign done_o               = &lane_valid;
  assign red_top_left_o       = red[0];
  assign green_top_left_o     = green[0];
  assign blue_top_left_o      = blue[0];
  assign red_top_right_o      = red[1];
  assign green_top_right_o    = green[1];
  assign blue_top_right_o     = blue[1];
  assign red_bottom_left_o    = red[2];
  assign green_bottom_left_o  = green[2];
  assign blue_bottom_left_o   = blue[2];
  assign red_bottom_right_o   = red[3];
  assign green_bottom_right_o = green[3];
  assign blue_bottom_right_o  = blue[3];

`ifndef SYNTHESIS
  // every accepted quad comes out after the pipeline latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 done_o)
    else $error("accepted quad did not produce a result");

  // no result without a matching quad accepted earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 5))
    else $error("result without accepted quad");

  // the four lanes move in lockstep
  a_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_valid == '0 || lane_valid == '1)
    else $error("pixel lanes out of step");
`endif

endmodule
